/* src/pnbp_pkg.sv */
package pnbp_pkg;

	localparam int NONCE_W      = 64;
	localparam int WIDTH_W      = 7;
	localparam int IDX_W        = 6;
	localparam int BYTE_BITS    = 8;
	localparam int PROOF_NONCES = 42;
	localparam int EDGE_MAX     = 64;
	localparam int EDGE_RESET   = 29;
	// live bits in the back end: up to seven pending plus one whole nonce
	localparam int ACC_W        = NONCE_W + BYTE_BITS - 1;
	localparam int TOT_W        = 7;
	localparam int PEND_W       = BYTE_BITS - 1;
	localparam int SHIFT_W      = 3;

	// classified nonce as it waits in the queue
	typedef struct packed {
		logic [NONCE_W-1:0] nonce;
		logic [WIDTH_W-1:0] width;
		logic               last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic             busy;
		logic [TOT_W-1:0] total;
	} back_stat_t;

endpackage

/* src/pnbp_front.sv */
module pnbp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pnbp_pkg::WIDTH_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	input  logic [pnbp_pkg::NONCE_W-1:0]        in_data,
	output logic                                in_ready,
	input  logic                                q_full,
	output logic                                push,
	output pnbp_pkg::item_t                     push_item
);
	import pnbp_pkg::*;

	logic [WIDTH_W-1:0] edge_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WIDTH_W-1:0] width;
	logic [NONCE_W-1:0] mask;
	logic               last;

	// widths above the nonce size clamp to the full nonce
	assign width = (edge_q > WIDTH_W'(EDGE_MAX)) ? WIDTH_W'(EDGE_MAX) : edge_q;
	assign mask  = (width >= WIDTH_W'(EDGE_MAX)) ? {NONCE_W{1'b1}}
	             : ((NONCE_W'(1) << width[SHIFT_W+2:0]) - NONCE_W'(1));
	assign last  = ({1'b0, idx_q} + (IDX_W+1)'(1)) >= (IDX_W+1)'(PROOF_NONCES);

	assign in_ready        = !q_full;
	assign push            = in_valid && !q_full;
	assign push_item.nonce = in_data & mask;
	assign push_item.width = width;
	assign push_item.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= WIDTH_W'(EDGE_RESET);
			idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				edge_q <= cfg_wdata;
			end
			if (push) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

endmodule

/* src/pnbp_queue.sv */
module pnbp_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pnbp_pkg::item_t        push_item,
	input  logic                   pop,
	output pnbp_pkg::item_t        head,
	output pnbp_pkg::queue_stat_t  stat
);
	import pnbp_pkg::*;

	item_t       mem [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign head       = mem[rd_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/pnbp_back.sv */
module pnbp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  pnbp_pkg::item_t                q_head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pnbp_pkg::BYTE_BITS-1:0] out_data,
	output logic                           out_last,
	output pnbp_pkg::back_stat_t           stat
);
	import pnbp_pkg::*;

	logic [ACC_W-1:0]     acc_q;
	logic [TOT_W-1:0]     total_q;
	logic                 busy_q;
	logic                 last_q;
	logic                 step;
	logic                 emit;
	logic                 emit_last;
	logic                 done;
	logic [ACC_W-1:0]     base_acc;
	logic [TOT_W-1:0]     base_total;
	logic [ACC_W-1:0]     load_acc;

	assign step = !out_valid || out_ready;

	always_comb begin
		emit       = 1'b0;
		emit_last  = 1'b0;
		done       = 1'b1;
		base_acc   = acc_q;
		base_total = total_q;
		if (busy_q) begin
			if (total_q >= TOT_W'(BYTE_BITS)) begin
				// whole byte ready
				emit       = 1'b1;
				emit_last  = last_q && (total_q == TOT_W'(BYTE_BITS));
				base_acc   = acc_q >> BYTE_BITS;
				base_total = total_q - TOT_W'(BYTE_BITS);
				done       = (base_total < TOT_W'(BYTE_BITS))
				          && (!last_q || base_total == '0);
			end else begin
				// tail: flush a partial byte at proof end
				emit      = last_q && (total_q != '0);
				emit_last = 1'b1;
			end
			if (done && last_q) begin
				base_acc   = '0;
				base_total = '0;
			end
		end
	end

	assign pop      = step && done && q_valid;
	assign load_acc = {{(ACC_W-PEND_W){1'b0}}, base_acc[PEND_W-1:0]}
	                | ({{(ACC_W-NONCE_W){1'b0}}, q_head.nonce} << base_total[SHIFT_W-1:0]);

	assign stat.busy  = busy_q;
	assign stat.total = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			total_q   <= '0;
			busy_q    <= 1'b0;
			last_q    <= 1'b0;
			out_valid <= 1'b0;
		end else if (step) begin
			out_valid <= emit;
			if (pop) begin
				acc_q   <= load_acc;
				total_q <= base_total + q_head.width;
				busy_q  <= 1'b1;
				last_q  <= q_head.last;
			end else begin
				acc_q   <= base_acc;
				total_q <= base_total;
				busy_q  <= busy_q && !done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data <= acc_q[BYTE_BITS-1:0];
			out_last <= emit_last;
		end
	end

endmodule

/* src/proof_nonce_bit_packer.sv */
// a nonce accepted on the input is written into the queue, then loaded into the bit
// accumulator, and its first byte is then registered into the output register
// throughput: one byte per cycle out of the single output register while the
// output is not stalled; a nonce is popped alongside the previous one's last byte
// reset: clears the queue, pending bits, nonce index and output; edge_bits to 29
module proof_nonce_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	// edge_bits register write
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	// nonce words in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] nonce_value
	// packed byte words out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] packed_byte
	output logic        m_axis_tlast    // last_byte of the proof
);
	import pnbp_pkg::*;

	logic        fr_push;
	item_t       fr_item;
	item_t       q_head;
	queue_stat_t q_stat;
	back_stat_t  bk_stat;
	logic        bk_pop;

	// front: holds edge_bits and the nonce index, masks each nonce and
	// tags the one that closes the proof
	pnbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_data   (s_axis_tdata),
		.in_ready  (s_axis_tready),
		.q_full    (q_stat.full),
		.push      (fr_push),
		.push_item (fr_item)
	);

	// two-entry queue decouples input acceptance from byte output
	pnbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_push),
		.push_item (fr_item),
		.pop       (bk_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// back: bit accumulator merges pending bits with the next nonce and peels off
	// one byte per cycle unless the output stalls, flushing the tail at proof end
	pnbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_stat.empty),
		.q_head    (q_head),
		.pop       (bk_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.stat      (bk_stat)
	);

	// queue cannot be full and empty at once
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty together");

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fr_push |-> !q_stat.full)
		else $error("push into full queue");

	// between nonces only a partial byte may remain
	a_idle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!bk_stat.busy |-> (bk_stat.total < 7'(BYTE_BITS)))
		else $error("whole byte left pending while idle");

	// accumulator never holds more than pending bits plus one nonce
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.total <= 7'(ACC_W))
		else $error("bit count beyond accumulator");

endmodule

/* sim/tb.sv */
module tb;
	import pnbp_pkg::*;

	// cycles with no word moving on either side before the run is called hung
	localparam int IDLE_LIMIT    = 1000;
	// quiet cycles after the last due byte, so a nonce that adds no byte clears the block
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int RANDOM_NONCES = 90;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data;
		logic                 last;
	} byte_word_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [WIDTH_W-1:0]   cfg_wdata     = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [NONCE_W-1:0]   s_axis_tdata  = '0;   // [63:0] nonce_value
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [BYTE_BITS-1:0] m_axis_tdata;         // [7:0] packed_byte
	logic                 m_axis_tlast;         // last_byte of the proof

	// packer state as the bench sees it, advanced at each accepted nonce
	logic [WIDTH_W-1:0]   edge_width  = WIDTH_W'(EDGE_RESET);
	logic [PEND_W-1:0]    carry_bits  = '0;
	int unsigned          carry_count = 0;
	int unsigned          proof_pos   = 0;

	// bytes the packer still owes, oldest first
	byte_word_t           due_bytes[$];
	int unsigned          mismatches  = 0;
	int unsigned          idle_cycles = 0;
	// calm stretches: no gaps on that side while set
	bit                   tx_calm     = 1'b0;
	bit                   rx_calm     = 1'b0;

	always #2 clk = ~clk;

	proof_nonce_bit_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// append the low bits of one nonce to the stream and queue the bytes it completes
	task automatic pack_nonce(input logic [NONCE_W-1:0] nonce);
		logic [BYTE_BITS-1:0] acc;
		logic [BYTE_BITS-1:0] done [0:8];
		int unsigned          span;
		int unsigned          fill;
		int unsigned          n;
		bit                   proof_end;
		// widths past the top of the range clamp to a full nonce
		span = (edge_width > EDGE_MAX) ? EDGE_MAX : edge_width;
		acc = {1'b0, carry_bits};
		fill = carry_count;
		n = 0;
		for (int k = 0; k < span; k++) begin
			acc[fill] = nonce[k];
			fill++;
			if (fill == BYTE_BITS) begin
				done[n] = acc;
				n++;
				acc = '0;
				fill = 0;
			end
		end
		proof_end = (proof_pos + 1 >= PROOF_NONCES);
		if (proof_end) begin
			// partial byte goes out zero padded; an aligned end marks the byte just made
			if (fill > 0) begin
				done[n] = acc;
				n++;
			end
			carry_bits = '0;
			carry_count = 0;
			proof_pos = 0;
		end else begin
			carry_bits = acc[PEND_W-1:0];
			carry_count = fill;
			proof_pos++;
		end
		// a zero-width last nonce with nothing pending marks no byte at all
		for (int i = 0; i < n; i++)
			due_bytes.insert(due_bytes.size(), {done[i], proof_end && (i == n - 1)});
	endtask

	// offer one nonce after a random gap; valid stays high across back-to-back words
	task automatic send_nonce(input logic [NONCE_W-1:0] nonce);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= nonce;
		do @(posedge clk); while (!s_axis_tready);
		pack_nonce(nonce);
	endtask

	// wait for every owed byte, then let any nonce that adds no byte pass through
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// edge_bits only changes while the packer is quiet; pending bits carry over
	task automatic set_edge(input logic [WIDTH_W-1:0] width);
		drain_and_settle();
		cfg_we <= 1'b1;
		cfg_wdata <= width;
		@(posedge clk);
		edge_width = width;
		cfg_we <= 1'b0;
	endtask

	// reset width of 29: plain patterns and bits that sit only above the edge
	task automatic test_reset_width();
		send_nonce('0);
		send_nonce('1);
		send_nonce(64'h5555_5555_5555_5555);
		send_nonce(~64'h0000_0000_1FFF_FFFF);
	endtask

	// full 64-bit nonces, then widths beyond 64 that clamp
	task automatic test_wide_edges();
		set_edge(WIDTH_W'(EDGE_MAX));
		send_nonce('1);
		send_nonce(64'h8000_0000_0000_0001);
		send_nonce({$urandom, $urandom});
		set_edge('1);
		send_nonce('1);
		send_nonce({$urandom, $urandom});
		set_edge(7'd65);
		send_nonce(64'hA5A5_5A5A_C3C3_3C3C);
	endtask

	// one bit per nonce: eight nonces build a byte, upper junk ignored
	task automatic test_single_bit();
		set_edge(7'd1);
		for (int i = 0; i < 9; i++)
			send_nonce({$urandom, 31'($urandom), (i % 3) != 1});
	endtask

	// width changes while bits are still pending
	task automatic test_width_change();
		set_edge(7'd3);
		send_nonce(64'h0000_0000_0000_0005);
		send_nonce(64'hFFFF_FFFF_FFFF_FFFA);
		set_edge(7'd13);
		send_nonce(64'h0000_0000_0000_1ABC);
	endtask

	// zero-width nonces walk the proof index to its end cheaply
	task automatic fill_to(input int unsigned pos);
		set_edge('0);
		while (proof_pos != pos) send_nonce({$urandom, $urandom});
	endtask

	// the three ways a proof can end
	task automatic test_proof_end();
		// padded flush of a partial last byte
		fill_to(PROOF_NONCES - 1);
		set_edge((carry_count == PEND_W) ? 7'd2 : 7'd1);
		send_nonce('1);
		// last nonce adds nothing and nothing is pending: no byte is marked
		set_edge(7'd16);
		send_nonce(64'h0000_0000_0000_BEEF);
		fill_to(PROOF_NONCES - 1);
		send_nonce('1);
		// last nonce ends on a byte boundary: its final byte carries the mark
		fill_to(PROOF_NONCES - 1);
		set_edge(7'd24);
		send_nonce(64'h0000_0000_00C0_FFEE);
	endtask

	// random widths per phase, proofs run through and across width changes
	task automatic test_random_proofs(input int unsigned target);
		int unsigned        sent;
		int unsigned        run;
		int unsigned        pick;
		logic [WIDTH_W-1:0] width;
		logic [NONCE_W-1:0] nonce;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: width = '0;
				1: width = WIDTH_W'($urandom_range(EDGE_MAX + 1, 127));
				2: width = WIDTH_W'(EDGE_MAX);
				3: width = 7'd1;
				default: width = WIDTH_W'($urandom_range(1, EDGE_MAX));
			endcase
			set_edge(width);
			tx_calm = ($urandom_range(0, 3) == 0);
			run = $urandom_range(1, 40);
			repeat (run) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					nonce = '1;
				else if (pick == 1)
					nonce = '0;
				else
					nonce = {$urandom, $urandom};
				send_nonce(nonce);
				if (width != 0)
					sent++;
			end
		end
		tx_calm = 1'b0;
	endtask

	task automatic note_mismatch(input byte_word_t want, input byte_word_t got, input bit stray);
		if (mismatches < 10) begin
			if (stray)
				$display("unexpected byte word: data %02h last %0b", got.data, got.last);
			else
				$display("byte word mismatch: expected data %02h last %0b, got data %02h last %0b",
					want.data, want.last, got.data, got.last);
		end
		mismatches++;
	endtask

	// output side: random stall before each word, check each word taken
	initial begin : byte_sink
		int unsigned stall;
		byte_word_t  want;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			if (due_bytes.size() == 0) begin
				note_mismatch('0, {m_axis_tdata, m_axis_tlast}, 1'b1);
			end else begin
				want = due_bytes.pop_front();
				if (m_axis_tdata !== want.data || m_axis_tlast !== want.last)
					note_mismatch(want, {m_axis_tdata, m_axis_tlast}, 1'b0);
			end
		end
	end

	// hang detector: any word moving on either side restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_wide_edges();
		test_single_bit();
		test_width_change();
		test_proof_end();
		test_random_proofs(RANDOM_NONCES);
		drain_and_settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		// anything still owed at this point never arrived
		mismatches += due_bytes.size();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* proof_nonce_bit_packer.f */
src/pnbp_pkg.sv
src/pnbp_front.sv
src/pnbp_queue.sv
src/pnbp_back.sv
src/proof_nonce_bit_packer.sv
sim/tb.sv
